@@ rtl/core/tpag_pkg.sv @@
package tpag_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int DATA_BITS = 32;
  localparam int LEN_BITS  = 12;
  localparam int ADDR_BITS = 20;

  localparam int NUM_AXES   = 4;
  localparam int AXIS_W     = 2;
  localparam int DIM_W      = 3;
  localparam int LEN_W      = 13;
  localparam int PERM_W     = NUM_AXES * AXIS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_AXES = (MAX_DIMS < NUM_AXES) ? MAX_DIMS : NUM_AXES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_LEN_AXIS0 = 3'd1,
    REG_LEN_AXIS1 = 3'd2,
    REG_LEN_AXIS2 = 3'd3,
    REG_LEN_AXIS3 = 3'd4,
    REG_PERM_CODE = 3'd5
  } cfg_reg_e;

  // per tensor geometry handed from the setup pipeline to the address walker
  typedef struct packed {
    logic [NUM_AXES-1:0][LEN_BITS-1:0]  lenm1;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] delta;
    logic                               err;
  } geom_t;

endpackage

@@ rtl/core/tensor_permute_address_generator.sv @@
// Scatter address generator for a permutation of a tensor with up to four axes.
// Input channel (in_valid_i/in_ready_o, elem_value_i): one element per
// transaction in source row-major order, last axis fastest.
// Output channel (out_valid_o/out_ready_i): the element unchanged, its linear
// address in the permuted tensor, a last-element flag and a config error flag.
// Config port (cfg_we_i, cfg_idx_i, cfg_data_i): single-cycle writes; the
// geometry is taken up at the first element of each tensor.
// A result is registered and appears in the cycle after its input is accepted.
// Throughput is one transaction per cycle while the receiver keeps up, as the
// address walks by one add per element. A 7-stage pipeline sets up strides and
// step offsets; in_ready_o stays low after reset and each write till settled.
// Reset clears the index counters and running address and loads the default
// geometry (four axes of length 1, identity permutation).
// When the receiver stalls, the result is held in the output register and
// in_ready_o drops until it is taken.
module tensor_permute_address_generator import tpag_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DATA_BITS-1:0] elem_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_BITS-1:0] out_value_o,
  output logic [ADDR_BITS-1:0]        dest_addr_o,
  output logic                        last_elem_o,
  output logic                        config_error_o
);

  geom_t geom;
  logic  settled;

  tpag_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom),
    .settled_o  (settled)
  );

  tpag_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .geom_i         (geom),
    .settled_i      (settled),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .elem_value_i   (elem_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .dest_addr_o    (dest_addr_o),
    .last_elem_o    (last_elem_o),
    .config_error_o (config_error_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction did not produce a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input accepted while geometry setup in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o && out_ready_i && last_elem_o
    |=> dest_addr_o == '0)
    else $error("first element of a tensor not at address zero");

endmodule

@@ rtl/core/tpag_cfg.sv @@
module tpag_cfg import tpag_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output geom_t                 geom_o,
  output logic                  settled_o
);

  localparam int SETTLE   = NUM_AXES + 3;
  localparam int SETTLE_W = $clog2(SETTLE + 1);
  localparam int QLEN_W   = LEN_BITS + 1;
  localparam int TOT_W    = ADDR_BITS + 2;
  localparam int PROD_W   = TOT_W + QLEN_W;
  localparam logic [TOT_W-1:0] ADDR_SPAN = TOT_W'(64'd1 << ADDR_BITS);
  localparam logic [TOT_W-1:0] TOT_SAT   = TOT_W'((64'd1 << ADDR_BITS) + 64'd1);

  logic [DIM_W-1:0]                   dim_q;
  logic [NUM_AXES-1:0][LEN_W-1:0]     len_q;
  logic [PERM_W-1:0]                  perm_q;
  logic [SETTLE_W-1:0]                settle_q;

  logic [DIM_W-1:0]                   dims_c;
  logic [NUM_AXES-1:0]                use_c;
  logic [NUM_AXES-1:0][QLEN_W-1:0]    len_c;
  logic [NUM_AXES-1:0][AXIS_W-1:0]    perm_c;
  logic [NUM_AXES-1:0][QLEN_W-1:0]    qlen_c;
  logic                               perm_err_c;

  logic [NUM_AXES-1:0]                use_q;
  logic [NUM_AXES-1:0][QLEN_W-1:0]    len_a_q;
  logic [NUM_AXES-1:0][LEN_BITS-1:0]  lenm1_q;
  logic [NUM_AXES-1:0][AXIS_W-1:0]    perm_a_q;
  logic [NUM_AXES-1:0][QLEN_W-1:0]    qlen_q;
  logic                               perm_err_q;

  logic [NUM_AXES-1:0][ADDR_BITS-1:0] stride_d;
  logic [NUM_AXES-1:0][ADDR_BITS-1:0] stride_q;
  logic [NUM_AXES-1:0][TOT_W-1:0]     tot_d;
  logic [NUM_AXES-1:0][TOT_W-1:0]     tot_q;
  logic [NUM_AXES-1:0][ADDR_BITS-1:0] c_d;
  logic [NUM_AXES-1:0][ADDR_BITS-1:0] c_q;
  logic [NUM_AXES-1:0][ADDR_BITS-1:0] w_q;
  logic [NUM_AXES-1:0][ADDR_BITS-1:0] delta_d;
  logic [NUM_AXES-1:0][ADDR_BITS-1:0] delta_q;
  logic                               err_q;

  // configuration registers and setup timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= DIM_W'(4);
      len_q    <= {NUM_AXES{LEN_W'(1)}};
      perm_q   <= PERM_W'(228);
      settle_q <= SETTLE_W'(SETTLE);
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_W'(SETTLE);
        case (cfg_reg_e'(cfg_idx_i))
          REG_DIM_COUNT: dim_q    <= cfg_data_i[DIM_W-1:0];
          REG_LEN_AXIS0: len_q[0] <= cfg_data_i[LEN_W-1:0];
          REG_LEN_AXIS1: len_q[1] <= cfg_data_i[LEN_W-1:0];
          REG_LEN_AXIS2: len_q[2] <= cfg_data_i[LEN_W-1:0];
          REG_LEN_AXIS3: len_q[3] <= cfg_data_i[LEN_W-1:0];
          REG_PERM_CODE: perm_q   <= cfg_data_i[PERM_W-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SETTLE_W'(1);
      end
    end
  end

  assign settled_o = (settle_q == '0);

  // clamp counts and lengths, check the permutation
  always_comb begin
    dims_c = dim_q;
    if (dims_c == '0) dims_c = DIM_W'(1);
    if (int'(dims_c) > MAX_AXES) dims_c = DIM_W'(MAX_AXES);
    perm_err_c = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      use_c[a]  = (a < int'(dims_c));
      perm_c[a] = perm_q[AXIS_W*a +: AXIS_W];
      if (!use_c[a] || len_q[a] == '0) begin
        len_c[a] = QLEN_W'(1);
      end else if (int'(len_q[a]) > (1 << LEN_BITS)) begin
        len_c[a] = QLEN_W'(1 << LEN_BITS);
      end else begin
        len_c[a] = QLEN_W'(len_q[a]);
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      if (use_c[i]) begin
        if (int'(perm_c[i]) >= int'(dims_c)) perm_err_c = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (perm_c[j] == perm_c[i]) perm_err_c = 1'b1;
        end
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      qlen_c[i] = use_c[i] ? len_c[perm_c[i]] : QLEN_W'(1);
    end
  end

  // output strides from the fastest output axis down, one product per stage
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_chain
    logic [TOT_W-1:0]  tot_prev;
    logic [PROD_W-1:0] tprod;
    if (k == NUM_AXES - 1) begin : g_last
      assign stride_d[k] = ADDR_BITS'(1);
    end else begin : g_mul
      assign stride_d[k] = ADDR_BITS'(stride_q[k+1] * ADDR_BITS'(qlen_q[k+1]));
    end
    if (k == 0) begin : g_first
      assign tot_prev = TOT_W'(1);
    end else begin : g_next
      assign tot_prev = tot_q[k-1];
    end
    assign tprod    = PROD_W'(tot_prev) * PROD_W'(len_a_q[k]);
    assign tot_d[k] = (tprod > PROD_W'(ADDR_SPAN)) ? TOT_SAT : TOT_W'(tprod);
  end

  // address weight of each source axis and the jump when it steps
  always_comb begin
    for (int b = 0; b < NUM_AXES; b++) begin
      c_d[b] = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        if (use_q[i] && perm_a_q[i] == AXIS_W'(b)) c_d[b] = c_d[b] + stride_q[i];
      end
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      delta_d[a] = c_q[a];
      for (int b = 0; b < NUM_AXES; b++) begin
        if (b > a) delta_d[a] = delta_d[a] - w_q[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    use_q      <= use_c;
    len_a_q    <= len_c;
    perm_a_q   <= perm_c;
    qlen_q     <= qlen_c;
    perm_err_q <= perm_err_c;
    for (int a = 0; a < NUM_AXES; a++) begin
      lenm1_q[a] <= LEN_BITS'(len_c[a] - QLEN_W'(1));
      w_q[a]     <= ADDR_BITS'(c_q[a] * ADDR_BITS'(lenm1_q[a]));
    end
    stride_q <= stride_d;
    tot_q    <= tot_d;
    c_q      <= c_d;
    delta_q  <= delta_d;
    err_q    <= perm_err_q | (tot_q[NUM_AXES-1] > ADDR_SPAN);
  end

  assign geom_o.lenm1 = lenm1_q;
  assign geom_o.delta = delta_q;
  assign geom_o.err   = err_q;

endmodule

@@ rtl/core/tpag_walk.sv @@
module tpag_walk import tpag_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  geom_t                       geom_i,
  input  logic                        settled_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [DATA_BITS-1:0] elem_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_BITS-1:0] out_value_o,
  output logic [ADDR_BITS-1:0]        dest_addr_o,
  output logic                        last_elem_o,
  output logic                        config_error_o
);

  logic                               at_start_q;
  logic [NUM_AXES-1:0][LEN_BITS-1:0]  idx_q;
  logic [NUM_AXES-1:0][LEN_BITS-1:0]  idx_d;
  logic [ADDR_BITS-1:0]               addr_q;
  logic [ADDR_BITS-1:0]               addr_d;
  logic [ADDR_BITS-1:0]               step;
  logic                               out_valid_q;
  logic signed [DATA_BITS-1:0]        out_value_q;
  logic [ADDR_BITS-1:0]               dest_addr_q;
  logic                               last_q;
  logic                               err_q;
  geom_t                              lat_q;
  geom_t                              eff;
  logic [NUM_AXES-1:0]                wrap;
  logic [NUM_AXES-1:0]                carry;
  logic                               last;
  logic                               take;

  // first element of a tensor uses the fresh geometry and latches it
  assign eff        = at_start_q ? geom_i : lat_q;
  assign in_ready_o = settled_i && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  // index odometer, last axis fastest
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      wrap[a] = (idx_q[a] == eff.lenm1[a]);
    end
    carry[NUM_AXES-1] = 1'b1;
    for (int a = NUM_AXES - 2; a >= 0; a--) begin
      carry[a] = carry[a+1] & wrap[a+1];
    end
    last = carry[0] & wrap[0];
    step = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (carry[a] && !wrap[a]) begin
        step     = step | eff.delta[a];
        idx_d[a] = idx_q[a] + LEN_BITS'(1);
      end else if (carry[a]) begin
        idx_d[a] = '0;
      end else begin
        idx_d[a] = idx_q[a];
      end
    end
    addr_d = last ? '0 : addr_q + step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q  <= 1'b1;
      idx_q       <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        at_start_q  <= last;
        idx_q       <= idx_d;
        addr_q      <= addr_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_value_q <= elem_value_i;
      dest_addr_q <= addr_q;
      last_q      <= last;
      err_q       <= eff.err;
      if (at_start_q) lat_q <= geom_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign dest_addr_o    = dest_addr_q;
  assign last_elem_o    = last_q;
  assign config_error_o = err_q;

endmodule

@@ tb/tb_tensor_permute_address_generator.sv @@
`timescale 1ns / 1ps

module tb_tensor_permute_address_generator;
  import tpag_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned STUCK_LIMIT  = 2000;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HI = 3'd7;

  localparam logic [PERM_W-1:0] IDENTITY_PERM   = 8'b11_10_01_00;
  localparam logic [PERM_W-1:0] PERM_SWAP_01    = 8'b11_11_00_01;
  localparam logic [PERM_W-1:0] PERM_LOW_PAIR   = 8'b00_00_01_00;
  localparam logic [PERM_W-1:0] PERM_NAMES_AX2  = 8'b00_00_00_10;
  localparam logic [PERM_W-1:0] PERM_INNER_SWAP = 8'b10_11_01_00;

  typedef struct {
    logic signed [DATA_BITS-1:0] value;
    logic [ADDR_BITS-1:0]        addr;
    logic                        last;
    logic                        err;
  } placed_elem_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i = REG_DIM_COUNT;
  logic [CFG_DATA_W-1:0]       cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic signed [DATA_BITS-1:0] elem_value_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [DATA_BITS-1:0] out_value_o;
  logic [ADDR_BITS-1:0]        dest_addr_o;
  logic                        last_elem_o;
  logic                        config_error_o;

  tensor_permute_address_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .elem_value_i   (elem_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .dest_addr_o    (dest_addr_o),
    .last_elem_o    (last_elem_o),
    .config_error_o (config_error_o)
  );

  always #4 clk_i = ~clk_i;

  // register file as written, and the geometry taken up at a tensor start
  logic [DIM_W-1:0]     sh_dims = 3'd4;
  logic [LEN_W-1:0]     sh_len [NUM_AXES] = '{default: 13'd1};
  logic [PERM_W-1:0]    sh_perm = IDENTITY_PERM;
  int unsigned          geo_dims;
  logic [LEN_BITS:0]    geo_len [NUM_AXES];
  logic [AXIS_W-1:0]    geo_src [NUM_AXES];
  logic [ADDR_BITS-1:0] geo_stride [NUM_AXES];
  logic                 geo_err;
  logic [LEN_BITS-1:0]  walk_idx [NUM_AXES] = '{default: '0};
  bit                   new_tensor = 1'b1;

  logic signed [DATA_BITS-1:0] elem_queue [$];
  placed_elem_t                placed_q [$];

  bit          in_took;
  bit          quiet_tail;
  bit          hold_request;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned stuck_cycles;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned tensors_done;
  int unsigned flagged;
  int unsigned settings_used;
  int unsigned mismatches;

  function automatic int unsigned shadow_dims();
    if (sh_dims == 0) return 1;
    if (sh_dims > MAX_AXES) return MAX_AXES;
    return 32'(sh_dims);
  endfunction

  function automatic logic [LEN_BITS:0] axis_len(input int a);
    if (a >= int'(shadow_dims()) || sh_len[a] == 0) return {{LEN_BITS{1'b0}}, 1'b1};
    if (sh_len[a] > (1 << LEN_BITS)) return {1'b1, {LEN_BITS{1'b0}}};
    return sh_len[a][LEN_BITS:0];
  endfunction

  function automatic void take_geometry();
    longint unsigned     volume;
    longint unsigned     span;
    logic [NUM_AXES-1:0] named;
    volume   = 1;
    span     = 1;
    named    = '0;
    geo_dims = shadow_dims();
    geo_err  = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      geo_len[a]    = axis_len(a);
      volume       *= geo_len[a];
      geo_src[a]    = sh_perm[AXIS_W*a +: AXIS_W];
      geo_stride[a] = '0;
      if (a < int'(geo_dims)) begin
        if (geo_src[a] >= geo_dims || named[geo_src[a]]) geo_err = 1'b1;
        named[geo_src[a]] = 1'b1;
      end
    end
    if (volume > (64'd1 << ADDR_BITS)) geo_err = 1'b1;
    for (int i = int'(geo_dims) - 1; i >= 0; i--) begin
      geo_stride[i] = span[ADDR_BITS-1:0];
      span *= geo_len[geo_src[i]];
    end
  endfunction

  function automatic void place_element(input logic signed [DATA_BITS-1:0] v);
    placed_elem_t    e;
    longint unsigned acc;
    bit              at_end;
    if (new_tensor) begin
      take_geometry();
      foreach (walk_idx[a]) walk_idx[a] = '0;
      new_tensor = 1'b0;
    end
    acc    = 0;
    at_end = 1'b1;
    for (int i = 0; i < int'(geo_dims); i++) begin
      acc += 64'(walk_idx[geo_src[i]]) * 64'(geo_stride[i]);
      if (walk_idx[i] + 1 != geo_len[i]) at_end = 1'b0;
    end
    e.value = v;
    e.addr  = acc[ADDR_BITS-1:0];
    e.last  = at_end;
    e.err   = geo_err;
    placed_q.push_back(e);
    if (at_end) begin
      foreach (walk_idx[a]) walk_idx[a] = '0;
      new_tensor = 1'b1;
    end else begin
      for (int a = int'(geo_dims) - 1; a >= 0; a--) begin
        if (walk_idx[a] + 1 < geo_len[a]) begin
          walk_idx[a]++;
          break;
        end
        walk_idx[a] = '0;
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 60)
      $display("mismatch on %s at result %0d: got %0d expected %0d",
               field, results_seen, got, want);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (elem_queue.size() != 0 && !quiet_tail && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else if (elem_queue.size() != 0) begin
        in_valid_i   <= 1'b1;
        elem_value_i <= elem_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      recv_stall   = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    placed_elem_t want;
    if (rst_ni) begin
      in_took = in_valid_i && in_ready_o;
      if (in_took) begin
        place_element(elem_value_i);
        items_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (placed_q.size() == 0) begin
          report_mismatch("transaction with nothing pending", dest_addr_o, 0);
        end else begin
          want = placed_q.pop_front();
          if (want.last) tensors_done++;
          if (want.err) flagged++;
          if (out_value_o !== want.value) report_mismatch("out_value", out_value_o, want.value);
          if (dest_addr_o !== want.addr) report_mismatch("dest_addr", dest_addr_o, want.addr);
          if (last_elem_o !== want.last) report_mismatch("last_elem", last_elem_o, want.last);
          if (config_error_o !== want.err)
            report_mismatch("config_error", config_error_o, want.err);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("tensor_permute_address_generator verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_DIM_COUNT: sh_dims = val[DIM_W-1:0];
      REG_LEN_AXIS0: sh_len[0] = val;
      REG_LEN_AXIS1: sh_len[1] = val;
      REG_LEN_AXIS2: sh_len[2] = val;
      REG_LEN_AXIS3: sh_len[3] = val;
      REG_PERM_CODE: sh_perm = val[PERM_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (elem_queue.size() != 0 || in_valid_i || placed_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic queue_elements(input int unsigned n);
    for (int k = 0; k < int'(n); k++) elem_queue.push_back($urandom());
  endtask

  initial begin
    int unsigned       eff;
    int unsigned       len_cap;
    int unsigned       tsize;
    int unsigned       n;
    int unsigned       j;
    int unsigned       tmp;
    int unsigned       random_items;
    int unsigned       order [NUM_AXES];
    logic [PERM_W-1:0] perm_bits;
    bit                hold_issued;

    random_items = 0;
    hold_issued  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: each element is a whole tensor at address zero
    elem_queue.push_back(32'sh7fffffff);
    elem_queue.push_back(32'sh80000000);
    elem_queue.push_back(32'sh00000000);
    wait_drained();

    // 2x3 transpose, junk in unused slots and unmapped registers
    set_reg(UNMAPPED_REG_LO, 13'h1fff);
    set_reg(UNMAPPED_REG_HI, 13'h0aaa);
    set_reg(REG_DIM_COUNT, 13'd2);
    set_reg(REG_LEN_AXIS0, 13'd2);
    set_reg(REG_LEN_AXIS1, 13'd3);
    set_reg(REG_LEN_AXIS2, 13'd0);
    set_reg(REG_LEN_AXIS3, 13'h1fff);
    set_reg(REG_PERM_CODE, {5'h1e, PERM_SWAP_01});
    end_writes();
    elem_queue.push_back(-32'sd1);
    elem_queue.push_back(32'sd1);
    elem_queue.push_back(32'sh55555555);
    elem_queue.push_back(32'shaaaaaaaa);
    queue_elements(2);
    wait_drained();

    // zero dim count and zero length
    set_reg(REG_DIM_COUNT, 13'd0);
    set_reg(REG_LEN_AXIS0, 13'd0);
    end_writes();
    queue_elements(2);
    wait_drained();

    // dim count above range, repeated axis in the permutation
    set_reg(REG_DIM_COUNT, 13'd7);
    set_reg(REG_LEN_AXIS0, 13'd1);
    set_reg(REG_LEN_AXIS1, 13'd2);
    set_reg(REG_LEN_AXIS2, 13'd1);
    set_reg(REG_LEN_AXIS3, 13'd2);
    set_reg(REG_PERM_CODE, {5'd0, PERM_LOW_PAIR});
    end_writes();
    queue_elements(4);
    wait_drained();

    // axis named beyond dim count, then a fix written in the middle of the tensor
    set_reg(REG_DIM_COUNT, 13'd2);
    set_reg(REG_LEN_AXIS0, 13'd2);
    set_reg(REG_LEN_AXIS1, 13'd2);
    set_reg(REG_PERM_CODE, {5'd0, PERM_NAMES_AX2});
    end_writes();
    queue_elements(2);
    wait_drained();
    set_reg(REG_PERM_CODE, {5'd0, PERM_LOW_PAIR});
    end_writes();
    queue_elements(6);

    while (random_items < RANDOM_ITEMS) begin
      wait_drained();
      if (random_items >= RANDOM_ITEMS * 4 / 5) quiet_tail = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        j = $urandom_range(0, 3);
        set_reg(REG_DIM_COUNT, (j == 0) ? 13'd0 : 13'(j + 4));
      end else begin
        set_reg(REG_DIM_COUNT, 13'($urandom_range(1, MAX_AXES)));
      end
      eff     = shadow_dims();
      len_cap = (eff == 1) ? 24 : (eff == 2) ? 8 : (eff == 3) ? 5 : 4;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (a < int'(eff)) begin
          set_reg(cfg_reg_e'(REG_LEN_AXIS0 + a),
                  ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, len_cap)));
        end else if ($urandom_range(0, 1) == 0) begin
          set_reg(cfg_reg_e'(REG_LEN_AXIS0 + a), 13'($urandom()));
        end
      end
      perm_bits = PERM_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) begin
        for (int a = 0; a < NUM_AXES; a++) order[a] = a;
        for (int a = int'(eff) - 1; a > 0; a--) begin
          j        = $urandom_range(0, a);
          tmp      = order[a];
          order[a] = order[j];
          order[j] = tmp;
        end
        for (int a = 0; a < int'(eff); a++) perm_bits[AXIS_W*a +: AXIS_W] = AXIS_W'(order[a]);
      end
      set_reg(REG_PERM_CODE, {5'($urandom()), perm_bits});
      if ($urandom_range(0, 3) == 0)
        set_reg(($urandom_range(0, 1) == 0) ? UNMAPPED_REG_LO : UNMAPPED_REG_HI,
                13'($urandom()));
      end_writes();

      tsize = 1;
      for (int a = 0; a < NUM_AXES; a++) tsize *= axis_len(a);
      n = $urandom_range(1, 3) * tsize;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, tsize - 1);
      if (n > 150) n = tsize;
      if (!hold_issued && random_items >= 200) begin
        n += 60;
        hold_issued  = 1'b1;
        hold_request = 1'b1;
      end
      queue_elements(n);
      random_items += n;
    end

    // oversized tensor with saturated lengths, inner axes swapped
    wait_drained();
    set_reg(REG_DIM_COUNT, 13'd4);
    set_reg(REG_LEN_AXIS0, 13'h1fff);
    set_reg(REG_LEN_AXIS1, 13'd4096);
    set_reg(REG_LEN_AXIS2, 13'd4096);
    set_reg(REG_LEN_AXIS3, 13'd4096);
    set_reg(REG_PERM_CODE, {5'd0, PERM_INNER_SWAP});
    end_writes();
    queue_elements(TAIL_ITEMS);
    wait_drained();
    repeat (10) @(posedge clk_i);

    while (placed_q.size() != 0) begin
      report_mismatch("missing transaction, dest_addr", 0, placed_q[0].addr);
      void'(placed_q.pop_front());
    end
    $display("run covered %0d elements, %0d complete tensors, %0d register settings",
             items_taken, tensors_done, settings_used);
    $display("%0d results flagged a config error, %0d mismatches seen", flagged, mismatches);
    if (mismatches == 0) begin
      $display("tensor_permute_address_generator verification clean");
    end else begin
      $display("tensor_permute_address_generator verification failed");
    end
    $finish;
  end

endmodule
